// ----- rtl/blf_pkg.sv -----
package blf_pkg;
	localparam int ROW_PIXELS = 32;
	localparam int RED_LIMIT_COUNT = 9;
	localparam int POS_W = $clog2(ROW_PIXELS + 1);
	localparam logic [21:0] DEG_K = 22'd3754939;
	localparam logic [7:0] RED_MIN = 8'd135;
	localparam int ACC_W = 64;
	localparam int SER_W = 32;

	typedef enum logic [1:0] {
		FUNC_IMU  = 2'd0,
		FUNC_PIX  = 2'd1,
		FUNC_TICK = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CFG_PGP = 3'd0, CFG_PGI = 3'd1, CFG_PGD = 3'd2, CFG_TGP = 3'd3,
		CFG_TGI = 3'd4, CFG_TGD = 3'd5, CFG_CRUISE = 3'd6, CFG_SETPT = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0, DIR_LEFT = 2'd1, DIR_RIGHT = 2'd2, DIR_BAD = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEG, ST_DEGFIN, ST_PTERM, ST_DTERM, ST_ITERM, ST_PFIN,
		ST_ROWFIN, ST_TP, ST_TD, ST_TI, ST_TFIN, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic signed [SER_W-1:0] mcand;
		logic [23:0] mplier;
		logic clear;
	} mac_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

// ----- rtl/balance_and_line_follow_pid.sv -----
// An IMU item keeps the block busy after its transfer for four bit-serial multiplies
// (angle, P, D and I terms) plus sequencing, the last pixel of a row for three, and a
// tick passes through ST_OUT, where any result is registered; other pixels need no more.
// Throughput: one item at a time; the shared shift-add multiplier serves every step.
// Reset (arst_n low, asynchronous) clears all controller state but the pitch sample
// register and loads the default gains, cruise speed and pitch setpoint.
module balance_and_line_follow_pid (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// tdata, from bit 0: func[1:0], pitch_sample[17:2], red_value[25:18], pad to 32
	input logic [31:0] s_tdata,
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	// tdata, from bit 0: linear_velocity[31:0], angular_velocity[63:32]
	output logic [63:0] m_tdata,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [23:0] cfg_data
);
	import blf_pkg::*;

	// Configuration registers.
	logic [23:0] pgp_q, pgi_q, pgd_q, tgp_q, tgi_q, tgd_q;
	logic [19:0] cruise_q;
	logic signed [15:0] setpt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgp_q <= 24'd9489; pgi_q <= 24'd66; pgd_q <= 24'd117965;
			tgp_q <= 24'd11796; tgi_q <= '0; tgd_q <= '0;
			cruise_q <= 20'd6554; setpt_q <= -16'sd1280;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PGP: pgp_q <= cfg_data;
				CFG_PGI: pgi_q <= cfg_data;
				CFG_PGD: pgd_q <= cfg_data;
				CFG_TGP: tgp_q <= cfg_data;
				CFG_TGI: tgi_q <= cfg_data;
				CFG_TGD: tgd_q <= cfg_data;
				CFG_CRUISE: cruise_q <= cfg_data[19:0];
				CFG_SETPT: setpt_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Controller state.
	state_t state_q, state_d;
	logic signed [23:0] last_perr_q, pint_q, perr_q, parea_q;
	logic signed [31:0] bal_corr_q, turn_cmd_q;
	logic balanced_q, red_seen_q;
	dir_t dir_q;
	logic [POS_W-1:0] pix_pos_q;
	logic [POS_W-1:0] red_cnt_q;
	logic [7:0] first_red_q;
	logic [7:0] line_err_q, last_line_err_q;
	logic signed [23:0] line_int_q;
	logic signed [15:0] sample_q;
	logic [63:0] out_q;
	logic out_valid_q;

	mac_ctl_t mac_ctl;
	logic mac_busy;
	logic signed [ACC_W-1:0] acc;

	blf_mac u_mac (.clk(clk), .arst_n(arst_n), .ctl(mac_ctl), .busy(mac_busy), .acc(acc));

	wire s_xfer = s_tvalid && s_tready;
	func_t in_func;
	assign in_func = func_t'(s_tdata[1:0]);
	wire [7:0] in_red = s_tdata[25:18];
	assign s_tready = (state_q == ST_IDLE) && !out_valid_q;

	// Degrees in Q8: round(sample * K / 2^22) with floor after adding half.
	logic signed [ACC_W-1:0] deg_t;
	logic signed [17:0] deg_w;
	logic signed [23:0] err_w, area_w;
	assign deg_t = acc + (ACC_W'(1) <<< 21);
	assign deg_w = 18'(deg_t >>> 22);
	assign err_w = 24'(5 * (24'(deg_w) - 24'(setpt_q)));
	assign area_w = pint_q + err_w;

	// Turn error update at row end.
	logic [7:0] lerr_n;
	dir_t dir_n;
	logic signed [25:0] lsum;
	logic signed [23:0] lint_n;
	always_comb begin
		lerr_n = line_err_q;
		dir_n = dir_q;
		if (red_cnt_q < POS_W'(RED_LIMIT_COUNT)) begin
			if (first_red_q <= 8'd5) begin
				lerr_n = 8'd5 - first_red_q;
				dir_n = DIR_LEFT;
			end else if (first_red_q >= 8'd18) begin
				lerr_n = first_red_q - 8'd18;
				dir_n = DIR_RIGHT;
			end
		end
		lsum = 26'(line_int_q) + 26'(lerr_n);
		if (lsum > 26'sd8388607) lint_n = 24'sh7fffff;
		else lint_n = lsum[23:0];
	end

	// Rounded shift for the pitch correction.
	logic signed [ACC_W-1:0] corr_t;
	assign corr_t = (acc + ACC_W'(128)) >>> 8;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_xfer) begin
				case (in_func)
					FUNC_IMU: state_d = ST_DEG;
					FUNC_PIX: if (s_tlast) state_d = ST_ROWFIN;
					FUNC_TICK: state_d = ST_OUT;
					default: ;
				endcase
			end
			ST_DEG: state_d = ST_DEGFIN;
			ST_DEGFIN: if (!mac_busy) state_d = ST_PTERM;
			ST_PTERM: state_d = ST_DTERM;
			ST_DTERM: if (!mac_busy) state_d = ST_ITERM;
			ST_ITERM: if (!mac_busy) state_d = ST_PFIN;
			ST_PFIN: if (!mac_busy) state_d = ST_IDLE;
			ST_ROWFIN: state_d = ST_TP;
			ST_TP: state_d = ST_TD;
			ST_TD: if (!mac_busy) state_d = ST_TI;
			ST_TI: if (!mac_busy) state_d = ST_TFIN;
			ST_TFIN: if (!mac_busy) state_d = ST_IDLE;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Multiplier launches; a step waits while the previous multiply runs.
	always_comb begin
		mac_ctl = '0;
		case (state_q)
			ST_DEG: begin
				mac_ctl.start = 1'b1; mac_ctl.clear = 1'b1;
				mac_ctl.mcand = 32'(sample_q); mac_ctl.mplier = 24'(DEG_K);
			end
			ST_PTERM: begin
				mac_ctl.start = 1'b1; mac_ctl.clear = 1'b1;
				mac_ctl.mcand = 32'(perr_q); mac_ctl.mplier = pgp_q;
			end
			ST_DTERM: if (!mac_busy) begin
				mac_ctl.start = 1'b1;
				mac_ctl.mcand = 32'(perr_q) - 32'(last_perr_q); mac_ctl.mplier = pgd_q;
			end
			ST_ITERM: if (!mac_busy) begin
				mac_ctl.start = 1'b1;
				mac_ctl.mcand = 32'(parea_q); mac_ctl.mplier = pgi_q;
			end
			ST_TP: begin
				mac_ctl.start = 1'b1; mac_ctl.clear = 1'b1;
				mac_ctl.mcand = 32'(line_err_q); mac_ctl.mplier = tgp_q;
			end
			ST_TD: if (!mac_busy) begin
				mac_ctl.start = 1'b1;
				mac_ctl.mcand = 32'(line_err_q) - 32'(last_line_err_q);
				mac_ctl.mplier = tgd_q;
			end
			ST_TI: if (!mac_busy) begin
				mac_ctl.start = 1'b1;
				mac_ctl.mcand = 32'(line_int_q); mac_ctl.mplier = tgi_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_perr_q <= '0; pint_q <= '0; perr_q <= '0; parea_q <= '0;
			bal_corr_q <= '0; turn_cmd_q <= '0; balanced_q <= 1'b0;
			red_seen_q <= 1'b0; dir_q <= DIR_NONE; pix_pos_q <= '0;
			red_cnt_q <= '0; first_red_q <= '0; line_err_q <= '0;
			last_line_err_q <= '0; line_int_q <= '0; out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_xfer && in_func == FUNC_PIX) begin
					if (pix_pos_q < POS_W'(ROW_PIXELS)) begin
						if (in_red >= RED_MIN) begin
							if (!red_seen_q) begin
								first_red_q <= 8'(3 * pix_pos_q + 1);
								red_seen_q <= 1'b1;
							end
							red_cnt_q <= red_cnt_q + 1'b1;
						end
						pix_pos_q <= pix_pos_q + 1'b1;
					end
				end
				ST_DEGFIN: if (!mac_busy) begin
					if (deg_w > -18'sd1536 && deg_w < 18'sd1536) balanced_q <= 1'b1;
					perr_q <= err_w;
					parea_q <= (area_w > 24'sd914 || area_w < -24'sd640) ? '0 : area_w;
				end
				ST_PFIN: if (!mac_busy) begin
					bal_corr_q <= sat32(corr_t);
					pint_q <= parea_q;
					last_perr_q <= perr_q;
				end
				ST_ROWFIN: begin
					line_err_q <= lerr_n;
					dir_q <= dir_n;
					line_int_q <= lint_n;
					balanced_q <= 1'b0;
					pix_pos_q <= '0; red_cnt_q <= '0; first_red_q <= '0;
					red_seen_q <= 1'b0;
				end
				ST_TFIN: if (!mac_busy) begin
					turn_cmd_q <= sat32(acc);
					last_line_err_q <= line_err_q;
				end
				ST_OUT: begin
					if (!balanced_q) begin
						out_q <= {32'd0, bal_corr_q};
						out_valid_q <= 1'b1;
					end else if (dir_q == DIR_LEFT) begin
						out_q <= {sat32(-ACC_W'(turn_cmd_q)), 12'd0, cruise_q};
						out_valid_q <= 1'b1;
					end else if (dir_q == DIR_RIGHT) begin
						out_q <= {turn_cmd_q, 12'd0, cruise_q};
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) sample_q <= s_tdata[17:2];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;
endmodule

// ----- rtl/blf_mac.sv -----
module blf_mac (
	input logic clk,
	input logic arst_n,
	input blf_pkg::mac_ctl_t ctl,
	output logic busy,
	output logic signed [blf_pkg::ACC_W-1:0] acc
);
	import blf_pkg::*;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mc_q;
	logic [23:0] mp_q;
	logic [4:0] cnt_q;
	logic busy_q;

	// Shift-add multiplier: one multiplier bit per cycle, product added to acc.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd24;
			if (ctl.clear) acc_q <= '0;
		end else if (busy_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mc_q <= ACC_W'(ctl.mcand);
			mp_q <= ctl.mplier;
		end else if (busy_q) begin
			mc_q <= mc_q <<< 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign busy = busy_q;
	assign acc = acc_q;
endmodule

// ----- tb/tb_balance_and_line_follow_pid.sv -----
`default_nettype none

// Scoreboard: a cycle-free copy of the controller arithmetic that turns each
// accepted input transfer into the velocity command it should cause, if any.
class VelocityBoard;
	typedef struct {
		logic signed [31:0] lin;
		logic signed [31:0] ang;
	} vel_cmd_t;

	vel_cmd_t cmd_q[$];
	int errors;

	logic [23:0] kp_pitch, ki_pitch, kd_pitch, kp_turn, ki_turn, kd_turn;
	logic [19:0] cruise;
	logic signed [15:0] setpoint;

	longint prev_perr, pitch_acc, correction, line_area, turn_cmd;
	bit balanced, seen;
	blf_pkg::dir_t dir;
	int pix_pos, red_cnt, first_pos, lerr, prev_lerr;

	function new();
		errors = 0;
		kp_pitch = 24'd9489; ki_pitch = 24'd66; kd_pitch = 24'd117965;
		kp_turn = 24'd11796; ki_turn = 24'd0; kd_turn = 24'd0;
		cruise = 20'd6554;
		setpoint = -16'sd1280;
		prev_perr = 0; pitch_acc = 0; correction = 0; line_area = 0; turn_cmd = 0;
		balanced = 0; seen = 0; dir = blf_pkg::DIR_NONE;
		pix_pos = 0; red_cnt = 0; first_pos = 0; lerr = 0; prev_lerr = 0;
	endfunction

	function void set_reg(blf_pkg::cfg_idx_t idx, logic [23:0] v);
		case (idx)
			blf_pkg::CFG_PGP: kp_pitch = v;
			blf_pkg::CFG_PGI: ki_pitch = v;
			blf_pkg::CFG_PGD: kd_pitch = v;
			blf_pkg::CFG_TGP: kp_turn = v;
			blf_pkg::CFG_TGI: ki_turn = v;
			blf_pkg::CFG_TGD: kd_turn = v;
			blf_pkg::CFG_CRUISE: cruise = v[19:0];
			default: setpoint = v[15:0];
		endcase
	endfunction

	// Round half up: add one half, then floor through the arithmetic shift.
	function longint round_down_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function longint clamp(longint v, longint lo, longint hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function void note_input(blf_pkg::func_t f, logic signed [15:0] smp,
		logic [7:0] red, bit last);
		longint deg, err, area, sum;
		vel_cmd_t c;
		case (f)
			blf_pkg::FUNC_IMU: begin
				deg = round_down_shift(longint'(smp) * 64'sd3754939, 22);
				if (deg > -1536 && deg < 1536) balanced = 1;
				err = 5 * (deg - longint'(setpoint));
				area = pitch_acc + err;
				// The integral is dumped, not clamped, when it leaves its window.
				if (area > 914 || area < -640) area = 0;
				sum = longint'(kp_pitch) * err + longint'(kd_pitch) * (err - prev_perr)
					+ longint'(ki_pitch) * area;
				correction = clamp(round_down_shift(sum, 8), -64'sd2147483648,
					64'sd2147483647);
				pitch_acc = area;
				prev_perr = err;
			end
			blf_pkg::FUNC_PIX: begin
				if (pix_pos < blf_pkg::ROW_PIXELS) begin
					if (red >= blf_pkg::RED_MIN) begin
						if (!seen) begin
							first_pos = 3 * pix_pos + 1;
							seen = 1;
						end
						red_cnt++;
					end
					pix_pos++;
				end
				if (last) begin
					if (red_cnt < blf_pkg::RED_LIMIT_COUNT) begin
						if (first_pos <= 5) begin
							lerr = 5 - first_pos;
							dir = blf_pkg::DIR_LEFT;
						end else if (first_pos >= 18) begin
							lerr = (first_pos - 18) & 8'hff;
							dir = blf_pkg::DIR_RIGHT;
						end
					end
					line_area = clamp(line_area + lerr, -64'sd8388608, 64'sd8388607);
					sum = longint'(kp_turn) * lerr + longint'(kd_turn) * (lerr - prev_lerr)
						+ longint'(ki_turn) * line_area;
					turn_cmd = clamp(sum, -64'sd2147483648, 64'sd2147483647);
					prev_lerr = lerr;
					balanced = 0;
					pix_pos = 0; red_cnt = 0; first_pos = 0; seen = 0;
				end
			end
			blf_pkg::FUNC_TICK: begin
				if (!balanced) begin
					c.lin = correction[31:0];
					c.ang = 32'sd0;
					cmd_q.push_back(c);
				end else if (dir == blf_pkg::DIR_LEFT || dir == blf_pkg::DIR_RIGHT) begin
					c.lin = {12'd0, cruise};
					c.ang = (dir == blf_pkg::DIR_LEFT) ?
						32'(clamp(-turn_cmd, -64'sd2147483648, 64'sd2147483647)) :
						turn_cmd[31:0];
					cmd_q.push_back(c);
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic signed [31:0] lin, logic signed [31:0] ang);
		vel_cmd_t c;
		if (cmd_q.size() == 0) begin
			$display("%0t: unexpected command lin=%0d ang=%0d", $time, lin, ang);
			errors++;
			return;
		end
		c = cmd_q.pop_front();
		if (lin !== c.lin) begin
			$display("%0t: linear_velocity expected %0d actual %0d", $time, c.lin, lin);
			errors++;
		end
		if (ang !== c.ang) begin
			$display("%0t: angular_velocity expected %0d actual %0d", $time, c.ang, ang);
			errors++;
		end
	endfunction

	function int pending();
		return cmd_q.size();
	endfunction
endclass

module tb_balance_and_line_follow_pid;
	timeunit 1ns;
	timeprecision 1ps;
	import blf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	// Percent chance per cycle that the sender holds back or the sink stalls.
	int idle_pct = 0;
	int stall_pct = 0;

	VelocityBoard board = new();

	balance_and_line_follow_pid u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sink side: values seen here are the ones from just before the edge, so a
	// transfer is checked exactly when the block saw tvalid and tready together.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_result(m_tdata[31:0], m_tdata[63:32]);
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// One input transfer. tvalid is left high afterwards so that back-to-back
	// transfers never drop it inside a time step; only an idle cycle or drain lowers it.
	task automatic send_item(func_t f, logic [15:0] smp, logic [7:0] red, bit last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, red, smp, f};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.note_input(f, smp, red, last);
	endtask

	task automatic send_imu(logic [15:0] smp);
		send_item(FUNC_IMU, smp, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_tick();
		send_item(FUNC_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// A row of len pixels. With a mark position only that pixel is red;
	// otherwise each pixel is red with the given chance.
	task automatic send_row(int len, int red_pct, int mark);
		logic [7:0] red;
		bit is_red;
		for (int k = 0; k < len; k++) begin
			is_red = (mark >= 0) ? (k == mark) : ($urandom_range(99) < red_pct);
			red = is_red ? 8'($urandom_range(135, 255)) : 8'($urandom_range(0, 134));
			send_item(FUNC_PIX, 16'($urandom), red, k == len - 1);
		end
	endtask

	// Registers change only with the block idle: every command has come back
	// and enough cycles have passed for an IMU update with no result to end.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		board.set_reg(idx, v);
	endtask

	task automatic load_gains(int setting);
		logic [23:0] v [8];
		case (setting)
			0: v = '{24'd9489, 24'd66, 24'd117965, 24'd11796, 24'd0, 24'd0,
				24'd6554, 24'hfffb00};
			1: v = '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
				24'hffffff, 24'h0fffff, 24'd23040};
			2: v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'hffa600};
			default: begin
				for (int i = 0; i < 7; i++) v[i] = 24'($urandom);
				v[6] = 24'($urandom_range(0, 1048575));
				v[7] = 24'($urandom_range(0, 46080) - 23040);
			end
		endcase
		for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(int count);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 25) begin
				// Mostly near level so that ticks see the balanced flag set.
				if ($urandom_range(3) != 0) send_imu(16'($urandom_range(0, 3000) - 1500));
				else send_imu(16'($urandom_range(0, 32768) - 16384));
				sent++;
			end else if (r < 55) begin
				r = $urandom_range(9);
				len = (r < 7) ? 32 : (r < 9) ? $urandom_range(1, 31) : $urandom_range(33, 40);
				if ($urandom_range(1) == 1) send_row(len, 0, $urandom_range(0, len - 1));
				else send_row(len, (r % 3 == 0) ? 60 : (r % 3 == 1) ? 15 : 3, -1);
				sent += len;
			end else if (r < 95) begin
				send_tick();
				sent++;
			end else begin
				send_item(FUNC_NONE, 16'($urandom), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset gains: a tick before any IMU data, pitch extremes,
		// the balance window, and the left, kept and crowded row cases.
		send_tick();
		send_imu(16'h c000);
		send_tick();
		send_imu(16'h4000);
		send_imu(16'h0000);
		send_tick();
		send_item(FUNC_PIX, 16'hffff, 8'd134, 1'b0);
		send_item(FUNC_PIX, 16'h0000, 8'd135, 1'b1);
		send_imu(16'd100);
		send_tick();
		send_row(3, 0, 6);
		send_imu(16'hff9c);
		send_tick();
		send_row(4, 0, 2);
		send_imu(16'd0);
		send_tick();
		send_row(10, 100, -1);
		send_item(FUNC_PIX, 16'd0, 8'd255, 1'b1);
		send_item(FUNC_NONE, 16'hffff, 8'hff, 1'b1);
		send_imu(16'd0);
		send_tick();

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			load_gains(phase);
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 51; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 51; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			random_traffic(150);
		end
		drain();

		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

`default_nettype wire

// ----- sim.f -----
rtl/blf_pkg.sv
rtl/blf_mac.sv
rtl/balance_and_line_follow_pid.sv
tb/tb_balance_and_line_follow_pid.sv
